/* hw/rtl/software_timer_array_assert.svh */
// Assertion macros shared by the timer array RTL.
// Expects clk (and rst_n for SWTMR_ASSERT) in scope at every use; no other dependencies.
`ifndef SOFTWARE_TIMER_ARRAY_ASSERT_SVH
`define SOFTWARE_TIMER_ARRAY_ASSERT_SVH

`ifndef SYNTHESIS

// checked outside reset
`define SWTMR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define SWTMR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define SWTMR_ASSERT(label, prop, msg)
`define SWTMR_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* hw/rtl/swtmr_pkg.sv */
// Shared constants, codes and controller/datapath structs for the timer array.
// No dependencies.
package swtmr_pkg;

    localparam int DEF_SLOTS       = 16;
    localparam int DEF_COUNT_BITS  = 32;
    localparam int DEF_TARGET_BITS = 32;

    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 4;
    localparam int FIELD_W  = 32;
    localparam int MODE_W   = 2;

    localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REGISTER = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_PERIODIC       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONESHOT_KEEP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONESHOT_REMOVE = 2'd2;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    localparam logic STAT_DONE     = 1'b0;
    localparam logic STAT_CONFLICT = 1'b1;

    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic rd_en;    // read slot table at scan index
        logic eval;     // update scanned slot, advance index
        logic flush;    // move held result to output as last
    } swtmr_cmd_t;

    typedef struct packed {
        logic fire;        // scanned slot reaches zero
        logic held_valid;  // a result is waiting in the hold register
        logic out_free;    // output register can load this cycle
        logic scan_last;   // scan index is at the last slot
    } swtmr_sts_t;

endpackage

/* hw/rtl/swtmr_ifs.sv */
// Request and response channel interfaces of the timer array.
// Depends on swtmr_pkg.
interface swtmr_req_if import swtmr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [FIELD_W-1:0]  count;
    logic [MODE_W-1:0]   mode;
    logic [FIELD_W-1:0]  target;

    modport source (output valid, action, slot, count, mode, target, input ready);
    modport sink   (input valid, action, slot, count, mode, target, output ready);
endinterface

interface swtmr_rsp_if import swtmr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [SLOT_W-1:0]  fired_slot;
    logic [FIELD_W-1:0] fired_target;
    logic               status;
    logic               last;

    modport source (output valid, kind, fired_slot, fired_target, status, last, input ready);
    modport sink   (input valid, kind, fired_slot, fired_target, status, last, output ready);
endinterface

/* hw/rtl/software_timer_array.sv */
// Timer array top level: request channel in, result channel out, slot table
// inside. Depends on swtmr_pkg, swtmr_ifs, swtmr_ctrl and swtmr_dp.
//
// A register or remove transaction is taken in the idle state and its single
// acknowledgement is loaded into the hold register, then moved to the output
// register in the flush state once the output register is free. A tick walks
// the slot table in slot order, reading each slot entry from the table in the
// read state and updating it in the eval state; the eval state waits while a
// fire result finds the hold register full and the output busy. The last fire
// result of a tick carries last; a tick where nothing fires gives no result. A
// new request is taken as soon as the previous one has handed its final result
// to the output register.
module software_timer_array import swtmr_pkg::*; #(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS,
    parameter int TARGET_BITS = DEF_TARGET_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    swtmr_req_if.sink   req,
    swtmr_rsp_if.source rsp
);

    swtmr_cmd_t cmd;
    swtmr_sts_t sts;

    swtmr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    swtmr_dp #(
        .SLOTS       (SLOTS),
        .COUNT_BITS  (COUNT_BITS),
        .TARGET_BITS (TARGET_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .req_action       (req.action),
        .req_slot         (req.slot),
        .req_count        (req.count),
        .req_mode         (req.mode),
        .req_target       (req.target),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_kind         (rsp.kind),
        .rsp_fired_slot   (rsp.fired_slot),
        .rsp_fired_target (rsp.fired_target),
        .rsp_status       (rsp.status),
        .rsp_last         (rsp.last)
    );

endmodule

/* hw/rtl/swtmr_dp.sv */
// Datapath of the timer array: slot table memory, active bits, scan index,
// hold register for the pending result and the output register.
// Depends on swtmr_pkg and software_timer_array_assert.svh.
`include "software_timer_array_assert.svh"

module swtmr_dp import swtmr_pkg::*; #(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS,
    parameter int TARGET_BITS = DEF_TARGET_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swtmr_cmd_t          cmd,
    output swtmr_sts_t          sts,
    input  logic [ACTION_W-1:0] req_action,
    input  logic [SLOT_W-1:0]   req_slot,
    input  logic [FIELD_W-1:0]  req_count,
    input  logic [MODE_W-1:0]   req_mode,
    input  logic [FIELD_W-1:0]  req_target,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic                rsp_kind,
    output logic [SLOT_W-1:0]   rsp_fired_slot,
    output logic [FIELD_W-1:0]  rsp_fired_target,
    output logic                rsp_status,
    output logic                rsp_last
);

    localparam int IDX_W = $clog2(SLOTS);

    typedef struct packed {
        logic [COUNT_BITS-1:0]  count;
        logic [COUNT_BITS-1:0]  reload;
        logic [MODE_W-1:0]      mode;
        logic [TARGET_BITS-1:0] target;
    } entry_t;

    entry_t entry_mem [SLOTS];
    entry_t rd_data_reg;

    logic [SLOTS-1:0] active_reg, active_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic               held_valid_reg, held_valid_next;
    logic               held_kind_reg;
    logic [SLOT_W-1:0]  held_slot_reg;
    logic [FIELD_W-1:0] held_target_reg;
    logic               held_status_reg;

    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [FIELD_W-1:0] out_target_reg;
    logic               out_status_reg;
    logic               out_last_reg;

    logic [IDX_W-1:0]      req_idx;
    logic                  req_in_range;
    logic                  req_active;
    logic                  reg_ok, rem_ok, is_reg, is_rem;
    logic                  cur_active, live, fire;
    logic [COUNT_BITS-1:0] cnt_dec, cnt_new;
    logic                  out_free;
    logic                  held_load_ack, held_load_fire, out_load_mid;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    // request decode
    always_comb
    begin
        req_idx      = IDX_W'(req_slot);
        req_in_range = (32'(req_slot) < 32'(SLOTS));
        req_active   = active_reg[req_idx];
        is_reg       = (req_action == ACT_REGISTER);
        is_rem       = (req_action == ACT_REMOVE);
        reg_ok       = cmd.accept && is_reg && req_in_range && !req_active;
        rem_ok       = cmd.accept && is_rem && req_in_range && req_active;
    end

    // slot update during a tick scan
    always_comb
    begin
        cur_active = active_reg[idx_reg];
        cnt_dec    = rd_data_reg.count - COUNT_BITS'(1);
        live       = cur_active && (rd_data_reg.count != '0);
        fire       = live && (cnt_dec == '0);
        if (fire && rd_data_reg.mode == MODE_PERIODIC)
        begin
            cnt_new = rd_data_reg.reload;
        end
        else
        begin
            cnt_new = cnt_dec;
        end
    end

    always_comb
    begin
        out_free       = !out_valid_reg || rsp_ready;
        held_load_ack  = cmd.accept && (is_reg || is_rem);
        held_load_fire = cmd.eval && fire;
        out_load_mid   = held_load_fire && held_valid_reg;

        sts.fire       = fire;
        sts.held_valid = held_valid_reg;
        sts.out_free   = out_free;
        sts.scan_last  = (idx_reg == IDX_W'(SLOTS - 1));
    end

    // memory write port: arm on register, write back on scan
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = rd_data_reg;
        if (reg_ok)
        begin
            mem_we           = 1'b1;
            mem_waddr        = req_idx;
            mem_wdata.count  = COUNT_BITS'(req_count);
            mem_wdata.reload = COUNT_BITS'(req_count);
            mem_wdata.mode   = req_mode;
            mem_wdata.target = TARGET_BITS'(req_target);
        end
        else if (cmd.eval && live)
        begin
            mem_we          = 1'b1;
            mem_wdata.count = cnt_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= entry_mem[idx_reg];
        end
    end

    always_comb
    begin
        active_next = active_reg;
        if (reg_ok)
        begin
            active_next[req_idx] = 1'b1;
        end
        if (rem_ok)
        begin
            active_next[req_idx] = 1'b0;
        end
        if (held_load_fire && rd_data_reg.mode == MODE_ONESHOT_REMOVE)
        begin
            active_next[idx_reg] = 1'b0;
        end

        idx_next = idx_reg;
        if (cmd.accept)
        begin
            idx_next = '0;
        end
        else if (cmd.eval)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        held_valid_next = held_valid_reg;
        if (held_load_ack || held_load_fire)
        begin
            held_valid_next = 1'b1;
        end
        else if (cmd.flush)
        begin
            held_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load_mid || cmd.flush)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            idx_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold and output payload
    always_ff @(posedge clk)
    begin
        if (held_load_ack)
        begin
            held_kind_reg   <= KIND_ACK;
            held_slot_reg   <= req_slot;
            held_target_reg <= '0;
            held_status_reg <= (is_reg ? reg_ok : rem_ok) ? STAT_DONE : STAT_CONFLICT;
        end
        else if (held_load_fire)
        begin
            held_kind_reg   <= KIND_FIRE;
            held_slot_reg   <= SLOT_W'(idx_reg);
            held_target_reg <= FIELD_W'(rd_data_reg.target);
            held_status_reg <= STAT_DONE;
        end

        if (out_load_mid || cmd.flush)
        begin
            out_kind_reg   <= held_kind_reg;
            out_slot_reg   <= held_slot_reg;
            out_target_reg <= held_target_reg;
            out_status_reg <= held_status_reg;
            out_last_reg   <= cmd.flush;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_kind         = out_kind_reg;
    assign rsp_fired_slot   = out_slot_reg;
    assign rsp_fired_target = out_target_reg;
    assign rsp_status       = out_status_reg;
    assign rsp_last         = out_last_reg;

    `SWTMR_ASSERT(a_flush_marks_last, cmd.flush |=> (out_valid_reg && out_last_reg), "flushed result not shown as last")
    `SWTMR_ASSERT(a_mid_fire_room, out_load_mid |-> out_free, "pending fire result overwrote output")
    `SWTMR_ASSERT(a_ack_hold_empty, held_load_ack |-> !held_valid_reg, "ack loaded over a pending result")
    `SWTMR_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (active_reg == '0 && !out_valid_reg), "state not cleared in reset")

endmodule

/* hw/rtl/swtmr_ctrl.sv */
// Controller of the timer array: sequences request decode, the per-slot
// read/update scan of a tick and the hand-off of results to the output.
// Depends on swtmr_pkg and software_timer_array_assert.svh.
`include "software_timer_array_assert.svh"

module swtmr_ctrl import swtmr_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [ACTION_W-1:0] req_action,
    output logic                req_ready,
    input  swtmr_sts_t          sts,
    output swtmr_cmd_t          cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   eval_stall;

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        // a second fire result cannot move the held one out while output is full
        eval_stall = sts.fire && sts.held_valid && !sts.out_free;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    unique case (req_action)
                        ACT_TICK:     state_next = ST_READ;
                        ACT_REGISTER: state_next = ST_FLUSH;
                        ACT_REMOVE:   state_next = ST_FLUSH;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!eval_stall)
                begin
                    cmd.eval   = 1'b1;
                    state_next = sts.scan_last ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH:
            begin
                if (!sts.held_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SWTMR_ASSERT(a_eval_holds, (state_reg == ST_EVAL && eval_stall) |=> (state_reg == ST_EVAL), "scan advanced past a blocked fire result")
    `SWTMR_ASSERT(a_idle_no_pending, (state_reg == ST_IDLE) |-> !sts.held_valid, "result left behind in hold register")

endmodule

/* tb/timer_table_checker.sv */
// Checker for the timer array: watches request and result transactions,
// keeps its own slot table and compares every result with the predicted one.
// Depends on swtmr_pkg and swtmr_ifs.
module timer_table_checker import swtmr_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    swtmr_req_if  req,
    swtmr_rsp_if  rsp,
    output int    errors,
    output int    outstanding
);

    localparam int NUM_SLOTS = DEF_SLOTS;

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] target;
        logic               status;
        logic               last;
    } timer_result_t;

    logic               slot_live   [NUM_SLOTS];
    logic [FIELD_W-1:0] slot_left   [NUM_SLOTS];
    logic [FIELD_W-1:0] slot_period [NUM_SLOTS];
    logic [FIELD_W-1:0] slot_addr   [NUM_SLOTS];
    logic [MODE_W-1:0]  slot_kind   [NUM_SLOTS];

    timer_result_t expected_results[$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    task automatic note_error(input string what, input logic [FIELD_W-1:0] want,
                              input logic [FIELD_W-1:0] got);
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        errors++;
    endtask

    // Applies one accepted request to the slot table and queues its results.
    task automatic predict_request(input logic [ACTION_W-1:0] action,
                                   input logic [SLOT_W-1:0]   slot,
                                   input logic [FIELD_W-1:0]  count,
                                   input logic [MODE_W-1:0]   mode,
                                   input logic [FIELD_W-1:0]  target);
        timer_result_t r;
        int            fires;
        fires = 0;
        r.kind   = KIND_ACK;
        r.slot   = slot;
        r.target = '0;
        r.status = STAT_CONFLICT;
        r.last   = 1'b1;
        case (action)
            ACT_TICK:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_live[i] && slot_left[i] != '0)
                    begin
                        slot_left[i] = slot_left[i] - 1'b1;
                        if (slot_left[i] == '0)
                        begin
                            r.kind   = KIND_FIRE;
                            r.slot   = i[SLOT_W-1:0];
                            r.target = slot_addr[i];
                            r.status = STAT_DONE;
                            r.last   = 1'b0;
                            expected_results.push_back(r);
                            fires++;
                            // mode three behaves as one-shot keep
                            if (slot_kind[i] == MODE_PERIODIC)
                                slot_left[i] = slot_period[i];
                            else if (slot_kind[i] == MODE_ONESHOT_REMOVE)
                                slot_live[i] = 1'b0;
                        end
                    end
                end
                if (fires > 0)
                    expected_results[expected_results.size()-1].last = 1'b1;
            end
            ACT_REGISTER:
            begin
                if (!slot_live[slot])
                begin
                    slot_live[slot]   = 1'b1;
                    slot_left[slot]   = count;
                    slot_period[slot] = count;
                    slot_kind[slot]   = mode;
                    slot_addr[slot]   = target;
                    r.status          = STAT_DONE;
                end
                expected_results.push_back(r);
            end
            ACT_REMOVE:
            begin
                if (slot_live[slot])
                begin
                    slot_live[slot] = 1'b0;
                    r.status        = STAT_DONE;
                end
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                slot_live[i] = 1'b0;
            expected_results.delete();
        end
        else
        begin
            // results first: a result never belongs to a request taken this edge
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual slot %0h",
                             $time, rsp.fired_slot);
                    errors++;
                end
                else
                begin
                    timer_result_t want;
                    want = expected_results.pop_front();
                    if (rsp.kind !== want.kind)
                        note_error("kind", want.kind, rsp.kind);
                    if (rsp.fired_slot !== want.slot)
                        note_error("fired_slot", want.slot, rsp.fired_slot);
                    if (rsp.fired_target !== want.target)
                        note_error("fired_target", want.target, rsp.fired_target);
                    if (rsp.status !== want.status)
                        note_error("status", want.status, rsp.status);
                    if (rsp.last !== want.last)
                        note_error("last", want.last, rsp.last);
                end
            end
            if (req.valid && req.ready)
                predict_request(req.action, req.slot, req.count, req.mode, req.target);
        end
        outstanding = expected_results.size();
    end

endmodule

/* tb/software_timer_array_tb.sv */
// Testbench top for the timer array: clock, reset, request stimulus, result
// back-pressure and the verdict. Depends on swtmr_pkg, swtmr_ifs,
// software_timer_array and timer_table_checker.
module software_timer_array_tb import swtmr_pkg::*; ();

    localparam logic [ACTION_W-1:0] ACT_SPARE  = 2'd3;
    localparam logic [MODE_W-1:0]   MODE_SPARE = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20000;
    localparam int TAIL_CYCLES  = 2 * DEF_SLOTS + 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int tx_idle_pct   = 21;
    int rx_idle_pct   = 58;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int errors;
    int outstanding;

    swtmr_req_if req_ch ();
    swtmr_rsp_if rsp_ch ();

    software_timer_array dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    timer_table_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served  <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_request(input logic [ACTION_W-1:0] action,
                                input logic [SLOT_W-1:0]   slot,
                                input logic [FIELD_W-1:0]  count,
                                input logic [MODE_W-1:0]   mode,
                                input logic [FIELD_W-1:0]  target);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= action;
        req_ch.slot   <= slot;
        req_ch.count  <= count;
        req_ch.mode   <= mode;
        req_ch.target <= target;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic send_tick();
        send_request(ACT_TICK, SLOT_W'($urandom_range(15)), $urandom,
                     MODE_W'($urandom_range(3)), $urandom);
    endtask

    // Mostly small counts so that slots fire; some zero and full-range counts.
    task automatic send_random_request();
        int               pick;
        int               size_pick;
        logic [FIELD_W-1:0] count;
        pick      = $urandom_range(99);
        size_pick = $urandom_range(9);
        if (size_pick == 0)
            count = '0;
        else if (size_pick < 8)
            count = $urandom_range(6, 1);
        else
            count = $urandom;
        if (pick < 45)
            send_tick();
        else if (pick < 75)
            send_request(ACT_REGISTER, SLOT_W'($urandom_range(15)), count,
                         MODE_W'($urandom_range(3)), $urandom);
        else if (pick < 95)
            send_request(ACT_REMOVE, SLOT_W'($urandom_range(15)), $urandom,
                         MODE_W'($urandom_range(3)), $urandom);
        else
            send_request(ACT_SPARE, SLOT_W'($urandom_range(15)), $urandom,
                         MODE_W'($urandom_range(3)), $urandom);
    endtask

    // Sender stays quiet until every expected result has come or the wait limit
    // runs out, then lets the block settle for a full tick.
    task automatic drain_results();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_TICK;
        req_ch.slot   = '0;
        req_ch.count  = '0;
        req_ch.mode   = MODE_PERIODIC;
        req_ch.target = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: conflicts, every mode, zero and full counts, spare codes
        send_request(ACT_REMOVE,   4'd0,  32'h0,        MODE_PERIODIC,       32'h0);
        send_request(ACT_REGISTER, 4'd0,  32'd1,        MODE_PERIODIC,       32'hFFFF_FFFF);
        send_request(ACT_REGISTER, 4'd0,  32'd5,        MODE_ONESHOT_KEEP,   32'h1234_5678);
        send_request(ACT_REGISTER, 4'd15, 32'd0,        MODE_ONESHOT_KEEP,   32'h0);
        send_request(ACT_REGISTER, 4'd1,  32'd2,        MODE_SPARE,          32'hAAAA_AAAA);
        send_request(ACT_REGISTER, 4'd2,  32'd1,        MODE_ONESHOT_REMOVE, 32'h5555_5555);
        send_request(ACT_REGISTER, 4'd3,  32'hFFFF_FFFF, MODE_PERIODIC,      32'hFFFF_FFFF);
        send_request(ACT_REGISTER, 4'd4,  32'd2,        MODE_ONESHOT_KEEP,   32'hDEAD_0001);
        send_tick();
        send_tick();
        send_tick();
        send_request(ACT_SPARE,    4'd15, 32'hFFFF_FFFF, MODE_SPARE,         32'hFFFF_FFFF);
        send_tick();
        send_request(ACT_REMOVE,   4'd2,  32'h0,        MODE_PERIODIC,       32'h0);
        send_request(ACT_REMOVE,   4'd1,  32'h0,        MODE_PERIODIC,       32'h0);
        send_request(ACT_REMOVE,   4'd4,  32'h0,        MODE_PERIODIC,       32'h0);
        send_request(ACT_REMOVE,   4'd15, 32'h0,        MODE_PERIODIC,       32'h0);
        send_request(ACT_REMOVE,   4'd3,  32'h0,        MODE_PERIODIC,       32'h0);
        send_request(ACT_REMOVE,   4'd0,  32'h0,        MODE_PERIODIC,       32'h0);
        send_request(ACT_REMOVE,   4'd0,  32'h0,        MODE_PERIODIC,       32'h0);
        send_tick();
        drain_results();

        for (int n = 0; n < 120; n++)
            send_random_request();
        drain_results();

        tx_idle_pct = 58;
        rx_idle_pct = 21;
        for (int n = 0; n < 120; n++)
            send_random_request();
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // fill the result path: many periodic slots firing while results stall
        for (int k = 4; k < 12; k++)
            send_request(ACT_REGISTER, k[SLOT_W-1:0], 32'd1, MODE_PERIODIC, $urandom);
        hold_requests++;
        for (int n = 0; n < 10; n++)
            send_tick();
        for (int n = 0; n < 100; n++)
            send_random_request();
        drain_results();

        if (errors == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #12000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/swtmr_pkg.sv
hw/rtl/swtmr_ifs.sv
hw/rtl/swtmr_dp.sv
hw/rtl/swtmr_ctrl.sv
hw/rtl/software_timer_array.sv
tb/timer_table_checker.sv
tb/software_timer_array_tb.sv
